/* design/assert_macros.svh */
// Assertion macros for the design file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gpio register block: invariant violated");

// A condition that must hold in the cycle after a trigger, outside of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpio register block: follow-up condition violated");

// A condition that must hold in the cycle after a trigger, checked during reset too.
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gpio register block: reset condition violated");

`endif

/* design/gpio_rb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the GPIO register block.
package gpio_rb_pkg;

    localparam int DEF_NUM_PINS  = 54;
    localparam int PORT_PINS     = 54;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 6;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_FSEL = 10;
    localparam int FSEL_FIELD_W  = 3;
    localparam int FSEL_W        = PINS_PER_FSEL * FSEL_FIELD_W;
    localparam int EN_GROUPS     = 6;
    localparam int IDX_W         = 3;

    // Register word map.
    localparam int SET_BASE  = 7;
    localparam int CLR_BASE  = 10;
    localparam int LEV_BASE  = 13;
    localparam int EDS_BASE  = 16;
    localparam int EN_BASE   = 19;
    localparam int EN_STRIDE = 3;

    // Function-select code that makes a pin an output.
    localparam logic [FSEL_FIELD_W-1:0] FSEL_OUTPUT = 3'd1;

    // Depth of the command queue and of the result queue.
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        K_NOP,
        K_RD_FSEL,
        K_RD_LEV,
        K_RD_EDS,
        K_RD_EN,
        K_WR_FSEL,
        K_WR_SET,
        K_WR_CLR,
        K_WR_EDS,
        K_WR_EN,
        K_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [IDX_W-1:0]       index;
        logic                   half;
        logic [DATA_W-1:0]      data;
        logic [PORT_PINS-1:0]   levels;
    } t_cmd;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } t_queue_status;

    // Bits of function-select word w that belong to pins that exist.
    function automatic logic [FSEL_W-1:0] fsel_word_mask(input logic [IDX_W-1:0] w,
                                                         input int num_pins);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
            if ((int'(w) * PINS_PER_FSEL + k) < num_pins) begin
                m[k*FSEL_FIELD_W +: FSEL_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

    // Upper or lower 32-bit half of a pin vector that is extended to 64 bits.
    function automatic logic [DATA_W-1:0] pick_half(input logic half,
                                                    input logic [2*DATA_W-1:0] v);
        return half ? v[2*DATA_W-1:DATA_W] : v[DATA_W-1:0];
    endfunction

endpackage

/* design/gpio_rb_front.sv */
`timescale 1ns / 1ps
// Front end: decodes incoming transactions into commands and queues them.
module gpio_rb_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    output logic                                    o_full,
    input  logic [1:0]                              i_opcode,
    input  logic [gpio_rb_pkg::ADDR_W-1:0]          i_word_address,
    input  logic [gpio_rb_pkg::DATA_W-1:0]          i_write_data,
    input  logic [gpio_rb_pkg::PORT_PINS-1:0]       i_pin_levels,
    output logic                                    o_cmd_valid,
    input  logic                                    i_cmd_ready,
    output gpio_rb_pkg::t_cmd                       o_cmd,
    output gpio_rb_pkg::t_queue_status              o_status
);

    localparam int DEPTH = gpio_rb_pkg::QUEUE_DEPTH;
    localparam int CW    = gpio_rb_pkg::QCNT_W;
    localparam int PW    = gpio_rb_pkg::QPTR_W;
    localparam int AW    = gpio_rb_pkg::ADDR_W;

    gpio_rb_pkg::t_cmd r_mem [DEPTH];
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;

    gpio_rb_pkg::t_cmd            w_cmd;
    logic                         w_fsel_hit;
    logic                         w_set_hit, w_clr_hit, w_lev_hit, w_eds_hit, w_en_hit;
    logic                         w_en_half;
    logic [gpio_rb_pkg::IDX_W-1:0] w_en_grp;
    logic                         w_push_ok;
    logic                         w_pop_ok;

    // Address decode.
    always_comb begin
        w_fsel_hit = i_word_address < AW'(gpio_rb_pkg::FSEL_WORDS);
        w_set_hit  = i_word_address inside {AW'(gpio_rb_pkg::SET_BASE),
                                            AW'(gpio_rb_pkg::SET_BASE + 1)};
        w_clr_hit  = i_word_address inside {AW'(gpio_rb_pkg::CLR_BASE),
                                            AW'(gpio_rb_pkg::CLR_BASE + 1)};
        w_lev_hit  = i_word_address inside {AW'(gpio_rb_pkg::LEV_BASE),
                                            AW'(gpio_rb_pkg::LEV_BASE + 1)};
        w_eds_hit  = i_word_address inside {AW'(gpio_rb_pkg::EDS_BASE),
                                            AW'(gpio_rb_pkg::EDS_BASE + 1)};
        w_en_hit   = 1'b0;
        w_en_half  = 1'b0;
        w_en_grp   = '0;
        for (int g = 0; g < gpio_rb_pkg::EN_GROUPS; g++) begin
            if (i_word_address == AW'(gpio_rb_pkg::EN_BASE + gpio_rb_pkg::EN_STRIDE * g)) begin
                w_en_hit  = 1'b1;
                w_en_half = 1'b0;
                w_en_grp  = gpio_rb_pkg::IDX_W'(g);
            end
            if (i_word_address ==
                AW'(gpio_rb_pkg::EN_BASE + gpio_rb_pkg::EN_STRIDE * g + 1)) begin
                w_en_hit  = 1'b1;
                w_en_half = 1'b1;
                w_en_grp  = gpio_rb_pkg::IDX_W'(g);
            end
        end
    end

    // Classification into a command for the back end.
    always_comb begin
        w_cmd.kind   = gpio_rb_pkg::K_NOP;
        w_cmd.index  = i_word_address[gpio_rb_pkg::IDX_W-1:0];
        w_cmd.half   = i_word_address[0];
        w_cmd.data   = i_write_data;
        w_cmd.levels = i_pin_levels;
        case (i_opcode)
            gpio_rb_pkg::OP_READ: begin
                if (w_fsel_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_RD_FSEL;
                end else if (w_lev_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_RD_LEV;
                    w_cmd.half = i_word_address == AW'(gpio_rb_pkg::LEV_BASE + 1);
                end else if (w_eds_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_RD_EDS;
                    w_cmd.half = i_word_address == AW'(gpio_rb_pkg::EDS_BASE + 1);
                end else if (w_en_hit) begin
                    w_cmd.kind  = gpio_rb_pkg::K_RD_EN;
                    w_cmd.index = w_en_grp;
                    w_cmd.half  = w_en_half;
                end
            end
            gpio_rb_pkg::OP_WRITE: begin
                if (w_fsel_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_WR_FSEL;
                end else if (w_set_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_WR_SET;
                    w_cmd.half = i_word_address == AW'(gpio_rb_pkg::SET_BASE + 1);
                end else if (w_clr_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_WR_CLR;
                    w_cmd.half = i_word_address == AW'(gpio_rb_pkg::CLR_BASE + 1);
                end else if (w_eds_hit) begin
                    w_cmd.kind = gpio_rb_pkg::K_WR_EDS;
                    w_cmd.half = i_word_address == AW'(gpio_rb_pkg::EDS_BASE + 1);
                end else if (w_en_hit) begin
                    w_cmd.kind  = gpio_rb_pkg::K_WR_EN;
                    w_cmd.index = w_en_grp;
                    w_cmd.half  = w_en_half;
                end
            end
            gpio_rb_pkg::OP_SAMPLE: begin
                w_cmd.kind = gpio_rb_pkg::K_SAMPLE;
            end
            default: begin
                w_cmd.kind = gpio_rb_pkg::K_NOP;
            end
        endcase
    end

    // Command queue.
    assign o_full      = r_count == CW'(DEPTH);
    assign o_cmd_valid = r_count != '0;
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_pop_ok    = o_cmd_valid && i_cmd_ready;

    assign o_status.count = r_count;
    assign o_status.full  = o_full;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* design/gpio_rb_back.sv */
`timescale 1ns / 1ps
// Back end: register state, command execution and the result queue.
module gpio_rb_back #(
    parameter int NUM_PINS = gpio_rb_pkg::DEF_NUM_PINS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cmd_valid,
    output logic                                    o_cmd_ready,
    input  gpio_rb_pkg::t_cmd                       i_cmd,
    output logic                                    o_empty,
    input  logic                                    i_pop,
    output logic [gpio_rb_pkg::DATA_W-1:0]          o_read_data,
    output logic [gpio_rb_pkg::PORT_PINS-1:0]       o_pin_drive,
    output logic [gpio_rb_pkg::PORT_PINS-1:0]       o_pin_function,
    output logic                                    o_event_pending,
    output gpio_rb_pkg::t_queue_status              o_status
);

    localparam int DEPTH  = gpio_rb_pkg::QUEUE_DEPTH;
    localparam int CW     = gpio_rb_pkg::QCNT_W;
    localparam int PW     = gpio_rb_pkg::QPTR_W;
    localparam int NP     = NUM_PINS;
    localparam int DW     = gpio_rb_pkg::DATA_W;
    localparam int PP     = gpio_rb_pkg::PORT_PINS;
    localparam int FW     = gpio_rb_pkg::FSEL_W;
    localparam int FFW    = gpio_rb_pkg::FSEL_FIELD_W;
    localparam int PPF    = gpio_rb_pkg::PINS_PER_FSEL;
    localparam int NFSEL  = gpio_rb_pkg::FSEL_WORDS;
    localparam int NEN    = gpio_rb_pkg::EN_GROUPS;

    typedef struct packed {
        logic [DW-1:0] read_data;
        logic [PP-1:0] pin_drive;
        logic [PP-1:0] pin_function;
        logic          event_pending;
    } t_result;

    // Architectural state.
    logic [FW-1:0] r_fsel [NFSEL];
    logic [FW-1:0] n_fsel [NFSEL];
    logic [NP-1:0] r_en [NEN];
    logic [NP-1:0] n_en [NEN];
    logic [NP-1:0] r_latch, n_latch;
    logic [NP-1:0] r_prev, n_prev;
    logic [NP-1:0] r_eds, n_eds;

    // Result queue.
    t_result       r_mem [DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;

    logic            w_exec;
    logic            w_pop_ok;
    t_result         w_res;
    logic [2*DW-1:0] w_word64;
    logic [2*DW-1:0] w_keep64;
    logic [63:0]     w_lev64;
    logic [NP-1:0]   w_wpins, w_keep, w_lev, w_rise, w_fall;
    logic [63:0]     w_latch64;
    logic [DW-1:0]   w_rd;

    assign o_cmd_ready = (r_count != CW'(DEPTH)) || i_pop;
    assign w_exec      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_fsel   = r_fsel;
        n_en     = r_en;
        n_latch  = r_latch;
        n_prev   = r_prev;
        n_eds    = r_eds;
        w_rd     = '0;
        w_word64 = i_cmd.half ? {i_cmd.data, {DW{1'b0}}} : {{DW{1'b0}}, i_cmd.data};
        w_keep64 = i_cmd.half ? {{DW{1'b0}}, {DW{1'b1}}} : {{DW{1'b1}}, {DW{1'b0}}};
        w_wpins  = w_word64[NP-1:0];
        w_keep   = w_keep64[NP-1:0];
        w_lev64  = 64'(i_cmd.levels);
        w_lev    = w_lev64[NP-1:0];
        w_rise   = w_lev & ~r_prev;
        w_fall   = ~w_lev & r_prev;
        case (i_cmd.kind)
            gpio_rb_pkg::K_RD_FSEL: w_rd = DW'(r_fsel[i_cmd.index]);
            gpio_rb_pkg::K_RD_LEV:  w_rd = gpio_rb_pkg::pick_half(i_cmd.half, 64'(r_prev));
            gpio_rb_pkg::K_RD_EDS:  w_rd = gpio_rb_pkg::pick_half(i_cmd.half, 64'(r_eds));
            gpio_rb_pkg::K_RD_EN: begin
                w_rd = gpio_rb_pkg::pick_half(i_cmd.half, 64'(r_en[i_cmd.index]));
            end
            gpio_rb_pkg::K_WR_FSEL: begin
                n_fsel[i_cmd.index] = i_cmd.data[FW-1:0] &
                                      gpio_rb_pkg::fsel_word_mask(i_cmd.index, NP);
            end
            gpio_rb_pkg::K_WR_SET: n_latch = r_latch | w_wpins;
            gpio_rb_pkg::K_WR_CLR: n_latch = r_latch & ~w_wpins;
            gpio_rb_pkg::K_WR_EDS: n_eds   = r_eds & ~w_wpins;
            gpio_rb_pkg::K_WR_EN: begin
                n_en[i_cmd.index] = (r_en[i_cmd.index] & w_keep) | w_wpins;
            end
            gpio_rb_pkg::K_SAMPLE: begin
                n_eds  = r_eds | (r_en[0] & w_rise) | (r_en[1] & w_fall)
                               | (r_en[2] & w_lev)  | (r_en[3] & ~w_lev)
                               | (r_en[4] & w_rise) | (r_en[5] & w_fall);
                n_prev = w_lev;
            end
            default: begin
                w_rd = '0;
            end
        endcase
    end

    // Result item, showing the state after the command.
    always_comb begin
        w_latch64           = 64'(n_latch);
        w_res.read_data     = w_rd;
        w_res.pin_drive     = w_latch64[PP-1:0];
        w_res.event_pending = |n_eds;
        for (int p = 0; p < PP; p++) begin
            w_res.pin_function[p] =
                n_fsel[p / PPF][(p % PPF) * FFW +: FFW] == gpio_rb_pkg::FSEL_OUTPUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NFSEL; i++) begin
                r_fsel[i] <= '0;
            end
            for (int i = 0; i < NEN; i++) begin
                r_en[i] <= '0;
            end
            r_latch <= '0;
            r_prev  <= '0;
            r_eds   <= '0;
        end else if (w_exec) begin
            r_fsel  <= n_fsel;
            r_en    <= n_en;
            r_latch <= n_latch;
            r_prev  <= n_prev;
            r_eds   <= n_eds;
        end
    end

    // Result queue control.
    assign o_empty  = r_count == '0;
    assign w_pop_ok = i_pop && !o_empty;

    assign o_read_data     = r_mem[r_rd_ptr].read_data;
    assign o_pin_drive     = r_mem[r_rd_ptr].pin_drive;
    assign o_pin_function  = r_mem[r_rd_ptr].pin_function;
    assign o_event_pending = r_mem[r_rd_ptr].event_pending;

    assign o_status.count = r_count;
    assign o_status.full  = r_count == CW'(DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_exec) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_exec && !w_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_exec && w_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_mem[r_wr_ptr] <= w_res;
        end
    end

endmodule

/* design/gpio_register_block_core.sv */
`timescale 1ns / 1ps
// Top level of the GPIO register block: front-end decoder, back end and checks.
//
// The block behaves as a queue on both sides. A transaction (register read,
// register write or pin-sample tick) is accepted at a rising edge where
// i_push is high and o_full is low. Every accepted transaction produces
// exactly one result transaction: the read data (zero for anything but a
// read of a readable word), the output latch, the per-pin output selection
// and the event-pending flag, all as they stand after that transaction.
// A result is on the o_ ports while o_empty is low and leaves the block at
// an edge where i_pop is high.
// The accepting edge writes the command queue; the command then runs through the
// back end into the result queue as soon as that queue has room or is popped,
// and o_empty falls once the result has been written.
// Throughput is one transaction per cycle while o_full is low; the back end does
// all register work of a transaction in one step, so the rate is set only by the
// two-entry command and result queues and by how fast results are popped.
// When the receiver stalls, the result queue fills first, then the command
// queue, and o_full rises; nothing is dropped.
// The synchronous, active-low reset empties both queues and clears all
// function-select, latch, level, status and detect-enable registers.
`include "assert_macros.svh"

module gpio_register_block_core #(
    parameter int NUM_PINS = gpio_rb_pkg::DEF_NUM_PINS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    output logic                                    o_full,
    input  logic [1:0]                              i_opcode,
    input  logic [gpio_rb_pkg::ADDR_W-1:0]          i_word_address,
    input  logic [gpio_rb_pkg::DATA_W-1:0]          i_write_data,
    input  logic [gpio_rb_pkg::PORT_PINS-1:0]       i_pin_levels,
    output logic                                    o_empty,
    input  logic                                    i_pop,
    output logic [gpio_rb_pkg::DATA_W-1:0]          o_read_data,
    output logic [gpio_rb_pkg::PORT_PINS-1:0]       o_pin_drive,
    output logic [gpio_rb_pkg::PORT_PINS-1:0]       o_pin_function,
    output logic                                    o_event_pending
);

    gpio_rb_pkg::t_cmd          w_cmd;
    logic                       w_cmd_valid;
    logic                       w_cmd_ready;
    gpio_rb_pkg::t_queue_status w_front_status;
    gpio_rb_pkg::t_queue_status w_back_status;

    // The front end decodes each transaction into a command and queues it.
    gpio_rb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_opcode       (i_opcode),
        .i_word_address (i_word_address),
        .i_write_data   (i_write_data),
        .i_pin_levels   (i_pin_levels),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_ready    (w_cmd_ready),
        .o_cmd          (w_cmd),
        .o_status       (w_front_status)
    );

    // The back end owns the registers and runs one command per cycle while
    // the result queue has room or a result is popped.
    gpio_rb_back #(
        .NUM_PINS (NUM_PINS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_ready     (w_cmd_ready),
        .i_cmd           (w_cmd),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_read_data     (o_read_data),
        .o_pin_drive     (o_pin_drive),
        .o_pin_function  (o_pin_function),
        .o_event_pending (o_event_pending),
        .o_status        (w_back_status)
    );

    // Both queues come out of reset empty.
    `ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, o_empty && !o_full)

    // An accepted transaction is held in the command queue on the next cycle.
    `ASSERT_NEXT(a_push_queued, i_clk, i_rst_n, i_push && !o_full, w_front_status.count != '0)

    // Neither queue ever holds more than its depth.
    `ASSERT_ALWAYS(a_back_bound, i_clk, i_rst_n,
        w_back_status.count <= gpio_rb_pkg::QCNT_W'(gpio_rb_pkg::QUEUE_DEPTH))

    `ASSERT_ALWAYS(a_front_bound, i_clk, i_rst_n,
        w_front_status.count <= gpio_rb_pkg::QCNT_W'(gpio_rb_pkg::QUEUE_DEPTH))

endmodule

/* tb/sv/gpio_register_block_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the GPIO register block with a built-in predictor.
module gpio_register_block_core_test;

    import gpio_rb_pkg::*;

    // The block is instantiated with its default pin count.
    localparam int NUM_PINS    = DEF_NUM_PINS;
    localparam int WORD_HALVES = 2;
    localparam int LAST_WORD   = (1 << ADDR_W) - 1;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AFTER   = 120;

    // Detect-enable groups in the order of their register pairs.
    localparam int EN_RISE  = 0;
    localparam int EN_FALL  = 1;
    localparam int EN_HIGH  = 2;
    localparam int EN_LOW   = 3;
    localparam int EN_ARISE = 4;
    localparam int EN_AFALL = 5;

    localparam logic [63:0] PIN_MASK = (64'd1 << NUM_PINS) - 64'd1;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [PORT_PINS-1:0] ALL_PINS = '1;

    typedef struct packed {
        t_opcode               op;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     data;
        logic [PORT_PINS-1:0]  levels;
    } gpio_access_t;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [PORT_PINS-1:0]  pin_drive;
        logic [PORT_PINS-1:0]  pin_function;
        logic                  event_pending;
    } gpio_result_t;

    // Ways in which the receiver drains the result side.
    typedef enum logic [1:0] {
        DRAIN_ALWAYS,
        DRAIN_HALF,
        DRAIN_SPARSE,
        DRAIN_PAIRS
    } drain_mode_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_push = 1'b0;
    logic                  i_pop = 1'b0;
    logic [1:0]            i_opcode = '0;
    logic [ADDR_W-1:0]     i_word_address = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic [PORT_PINS-1:0]  i_pin_levels = '0;
    logic                  o_full;
    logic                  o_empty;
    logic [DATA_W-1:0]     o_read_data;
    logic [PORT_PINS-1:0]  o_pin_drive;
    logic [PORT_PINS-1:0]  o_pin_function;
    logic                  o_event_pending;

    // Transactions waiting to be offered, and results predicted for accepted ones.
    gpio_access_t pending_accesses[$];
    gpio_result_t predicted_results[$];

    // Predictor copy of the register state.
    logic [FSEL_W-1:0] sel_words [FSEL_WORDS];
    logic [63:0]       drive_latch;
    logic [63:0]       last_levels;
    logic [63:0]       status_bits;
    logic [63:0]       enable_words [EN_GROUPS];

    int          mismatch_count = 0;
    int          accepted_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          mode_left = 0;
    drain_mode_t drain_mode = DRAIN_ALWAYS;
    logic [PORT_PINS-1:0] recent_levels = '0;

    gpio_register_block_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_opcode        (i_opcode),
        .i_word_address  (i_word_address),
        .i_write_data    (i_write_data),
        .i_pin_levels    (i_pin_levels),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_read_data     (o_read_data),
        .o_pin_drive     (o_pin_drive),
        .o_pin_function  (o_pin_function),
        .o_event_pending (o_event_pending)
    );

    // Free-running clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Places a 32-bit register word onto the pin vector, lower or upper half.
    function automatic logic [63:0] to_pin_bits(input logic upper, input logic [DATA_W-1:0] d);
        return (upper ? {d, 32'd0} : {32'd0, d}) & PIN_MASK;
    endfunction

    // Reads the lower or upper 32 pins of a pin vector as a register word.
    function automatic logic [DATA_W-1:0] from_pin_bits(input logic upper, input logic [63:0] v);
        return upper ? v[63:32] : v[31:0];
    endfunction

    // Applies one transaction to the predictor state and returns the result
    // that the block must report for it.
    function automatic gpio_result_t apply_access(input gpio_access_t acc);
        gpio_result_t      res;
        logic [FSEL_W-1:0] keep;
        logic [63:0]       lev;
        logic [63:0]       rise;
        logic [63:0]       fall;
        logic [63:0]       outs;
        int                a;
        int                grp;
        int                half_sel;
        res = '0;
        a = int'(acc.addr);
        grp = (a - EN_BASE) / EN_STRIDE;
        half_sel = (a - EN_BASE) % EN_STRIDE;
        case (acc.op)
            OP_READ: begin
                if (a < FSEL_WORDS) begin
                    res.read_data = DATA_W'(sel_words[a]);
                end else if (a == LEV_BASE || a == LEV_BASE + 1) begin
                    res.read_data = from_pin_bits(a == LEV_BASE + 1, last_levels);
                end else if (a == EDS_BASE || a == EDS_BASE + 1) begin
                    res.read_data = from_pin_bits(a == EDS_BASE + 1, status_bits);
                end else if (a >= EN_BASE && a < EN_BASE + EN_STRIDE * EN_GROUPS
                             && half_sel < WORD_HALVES) begin
                    res.read_data = from_pin_bits(half_sel == 1, enable_words[grp]);
                end
            end
            OP_WRITE: begin
                if (a < FSEL_WORDS) begin
                    keep = '0;
                    for (int k = 0; k < PINS_PER_FSEL; k++) begin
                        if (a * PINS_PER_FSEL + k < NUM_PINS) begin
                            keep[k*FSEL_FIELD_W +: FSEL_FIELD_W] = '1;
                        end
                    end
                    sel_words[a] = acc.data[FSEL_W-1:0] & keep;
                end else if (a == SET_BASE || a == SET_BASE + 1) begin
                    drive_latch |= to_pin_bits(a == SET_BASE + 1, acc.data);
                end else if (a == CLR_BASE || a == CLR_BASE + 1) begin
                    drive_latch &= ~to_pin_bits(a == CLR_BASE + 1, acc.data);
                end else if (a == EDS_BASE || a == EDS_BASE + 1) begin
                    status_bits &= ~to_pin_bits(a == EDS_BASE + 1, acc.data);
                end else if (a >= EN_BASE && a < EN_BASE + EN_STRIDE * EN_GROUPS
                             && half_sel < WORD_HALVES) begin
                    // Only the addressed half changes; the other half is kept.
                    enable_words[grp] = (enable_words[grp] & (half_sel == 1
                                         ? 64'h0000_0000_FFFF_FFFF
                                         : 64'hFFFF_FFFF_0000_0000))
                                        | to_pin_bits(half_sel == 1, acc.data);
                end
            end
            OP_SAMPLE: begin
                lev = 64'(acc.levels) & PIN_MASK;
                rise = lev & ~last_levels;
                fall = ~lev & last_levels & PIN_MASK;
                status_bits |= (enable_words[EN_RISE] & rise)
                             | (enable_words[EN_FALL] & fall)
                             | (enable_words[EN_HIGH] & lev)
                             | (enable_words[EN_LOW] & ~lev & PIN_MASK)
                             | (enable_words[EN_ARISE] & rise)
                             | (enable_words[EN_AFALL] & fall);
                status_bits &= PIN_MASK;
                last_levels = lev;
            end
            default: begin
            end
        endcase
        outs = '0;
        for (int p = 0; p < NUM_PINS && p < PINS_PER_FSEL * FSEL_WORDS; p++) begin
            if (sel_words[p / PINS_PER_FSEL][FSEL_FIELD_W * (p % PINS_PER_FSEL) +: FSEL_FIELD_W]
                    == FSEL_OUTPUT) begin
                outs[p] = 1'b1;
            end
        end
        res.pin_drive = drive_latch[PORT_PINS-1:0];
        res.pin_function = outs[PORT_PINS-1:0];
        res.event_pending = (status_bits != '0);
        return res;
    endfunction

    // Pin levels for the stimulus: mostly random, sometimes all low, all high
    // or unchanged, so that level conditions persist across ticks.
    function automatic logic [PORT_PINS-1:0] pick_levels();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: r = '0;
            1: r = '1;
            2, 3: r = 64'(recent_levels);
            default: begin
            end
        endcase
        recent_levels = r[PORT_PINS-1:0];
        return r[PORT_PINS-1:0];
    endfunction

    task automatic queue_access(input t_opcode op, input int addr,
                                input logic [DATA_W-1:0] d, input logic [PORT_PINS-1:0] lv);
        gpio_access_t acc;
        acc.op = op;
        acc.addr = ADDR_W'(addr);
        acc.data = d;
        acc.levels = lv;
        pending_accesses.push_back(acc);
    endtask

    // Sender: offers the oldest pending transaction in bursts of random length
    // separated by random gaps. The front of the queue leaves only when the
    // block accepts it, so a refused offer is simply repeated.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_push <= 1'b0;
            i_write_data <= $urandom;
        end else if (pending_accesses.size() == 0) begin
            i_push <= 1'b0;
        end else begin
            i_push <= 1'b1;
            i_opcode <= pending_accesses[0].op;
            i_word_address <= pending_accesses[0].addr;
            i_write_data <= pending_accesses[0].data;
            i_pin_levels <= pending_accesses[0].levels;
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // Receiver: drains results in one of several patterns, a new one picked at
    // random whenever the current one runs out. Once, after enough transactions
    // have gone through, it holds off for a long stretch so that both internal
    // queues fill and the block refuses further input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_pop <= 1'b0;
        end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                drain_mode = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            case (drain_mode)
                DRAIN_ALWAYS: i_pop <= 1'b1;
                DRAIN_HALF:   i_pop <= 1'($urandom_range(0, 1));
                DRAIN_SPARSE: i_pop <= ($urandom_range(0, 3) == 0);
                default:      i_pop <= mode_left[1];
            endcase
        end
    end

    // Checker and acceptance tracking at the rising edge. A result transaction
    // is compared first; an input transaction accepted at the same edge cannot have
    // produced it, since a transaction is registered in both queues before it shows.
    always @(posedge i_clk) begin
        gpio_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d transactions still pending, %0d results expected",
                     $time, pending_accesses.size(), predicted_results.size());
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, read_data %h drive %h", $time,
                             o_read_data, o_pin_drive);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_read_data !== want.read_data) begin
                        mismatch_count++;
                        $display("%0t: read_data expected %h, got %h", $time,
                                 want.read_data, o_read_data);
                    end
                    if (o_pin_drive !== want.pin_drive) begin
                        mismatch_count++;
                        $display("%0t: pin_drive expected %h, got %h", $time,
                                 want.pin_drive, o_pin_drive);
                    end
                    if (o_pin_function !== want.pin_function) begin
                        mismatch_count++;
                        $display("%0t: pin_function expected %h, got %h", $time,
                                 want.pin_function, o_pin_function);
                    end
                    if (o_event_pending !== want.event_pending) begin
                        mismatch_count++;
                        $display("%0t: event_pending expected %b, got %b", $time,
                                 want.event_pending, o_event_pending);
                    end
                end
            end
            if (i_push && !o_full) begin
                // Predict from the values on the ports, which are the ones taken.
                want = apply_access('{op: t_opcode'(i_opcode), addr: i_word_address,
                                      data: i_write_data, levels: i_pin_levels});
                predicted_results.push_back(want);
                void'(pending_accesses.pop_front());
                accepted_count++;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int                   grp;
        int                   half_sel;
        int                   w;
        logic [DATA_W-1:0]    d;

        for (int i = 0; i < FSEL_WORDS; i++) begin
            sel_words[i] = '0;
        end
        for (int i = 0; i < EN_GROUPS; i++) begin
            enable_words[i] = '0;
        end
        drive_latch = '0;
        last_levels = '0;
        status_bits = '0;

        // Directed part. Reset values, field extremes, every opcode, and the
        // special cases: write-only and read-only words, reserved words,
        // fields of pins that do not exist, status clear by writing one, and
        // a level condition that sets its status bit again after a clear.
        queue_access(OP_READ, 0, ALL_ONES, ALL_PINS);
        queue_access(OP_WRITE, 0, ALL_ONES, '0);
        queue_access(OP_WRITE, 0, 32'h0924_9249, '0);
        queue_access(OP_WRITE, FSEL_WORDS - 1, ALL_ONES, '0);
        queue_access(OP_READ, FSEL_WORDS - 1, '0, '0);
        queue_access(OP_WRITE, SET_BASE, ALL_ONES, '0);
        queue_access(OP_WRITE, SET_BASE + 1, ALL_ONES, '0);
        queue_access(OP_READ, SET_BASE, '0, '0);
        queue_access(OP_WRITE, CLR_BASE, 32'h5555_5555, '0);
        queue_access(OP_WRITE, CLR_BASE + 1, ALL_ONES, '0);
        queue_access(OP_WRITE, LEV_BASE, ALL_ONES, '0);
        queue_access(OP_WRITE, EN_BASE + EN_RISE * EN_STRIDE, ALL_ONES, '0);
        queue_access(OP_WRITE, EN_BASE + EN_HIGH * EN_STRIDE + 1, ALL_ONES, '0);
        queue_access(OP_SAMPLE, 0, '0, ALL_PINS);
        queue_access(OP_READ, LEV_BASE + 1, '0, '0);
        queue_access(OP_READ, EDS_BASE + 1, '0, '0);
        queue_access(OP_WRITE, EDS_BASE, ALL_ONES, '0);
        queue_access(OP_WRITE, EDS_BASE + 1, ALL_ONES, '0);
        queue_access(OP_SAMPLE, 0, '0, ALL_PINS);
        queue_access(OP_READ, EDS_BASE + 1, '0, '0);
        queue_access(OP_NONE, LAST_WORD, ALL_ONES, ALL_PINS);
        queue_access(OP_WRITE, EN_BASE + WORD_HALVES, ALL_ONES, '0);
        queue_access(OP_READ, EN_BASE + WORD_HALVES, '0, '0);
        queue_access(OP_WRITE, EN_BASE + EN_AFALL * EN_STRIDE + 1, ALL_ONES, '0);
        queue_access(OP_SAMPLE, 0, '0, '0);
        queue_access(OP_READ, LAST_WORD, '0, '0);

        // Random part. Most of it is short register sequences that arm the
        // detectors, tick the pins and read back or clear the status; the
        // rest is fully random traffic over every opcode and word.
        while (pending_accesses.size() < RANDOM_ITEMS + 26) begin
            d = ($urandom_range(0, 3) == 0) ? ALL_ONES : $urandom;
            half_sel = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0, 1: begin
                    grp = $urandom_range(0, EN_GROUPS - 1);
                    queue_access(OP_WRITE, EN_BASE + grp * EN_STRIDE + half_sel, d,
                                 pick_levels());
                    queue_access(OP_READ, EN_BASE + grp * EN_STRIDE + half_sel, $urandom,
                                 pick_levels());
                end
                2, 3, 4: begin
                    repeat ($urandom_range(1, 3)) begin
                        queue_access(OP_SAMPLE, $urandom_range(0, LAST_WORD), $urandom,
                                     pick_levels());
                    end
                    queue_access(OP_READ, EDS_BASE + half_sel, $urandom, pick_levels());
                    queue_access(OP_READ, LEV_BASE + half_sel, $urandom, pick_levels());
                end
                5: begin
                    queue_access(OP_WRITE, EDS_BASE + half_sel, d, pick_levels());
                end
                6: begin
                    // Function-select word with a mix of output and other modes.
                    w = $urandom_range(0, FSEL_WORDS - 1);
                    d = $urandom;
                    for (int k = 0; k < PINS_PER_FSEL; k++) begin
                        if ($urandom_range(0, 1) == 0) begin
                            d[k*FSEL_FIELD_W +: FSEL_FIELD_W] = FSEL_OUTPUT;
                        end
                    end
                    queue_access(OP_WRITE, w, d, pick_levels());
                    queue_access(OP_READ, w, $urandom, pick_levels());
                end
                7: begin
                    queue_access(OP_WRITE, ($urandom_range(0, 1) == 0 ? SET_BASE : CLR_BASE)
                                 + half_sel, d, pick_levels());
                end
                8: begin
                    queue_access(OP_READ, $urandom_range(0, LAST_WORD), $urandom,
                                 pick_levels());
                end
                default: begin
                    queue_access(t_opcode'($urandom_range(0, 3)), $urandom_range(0, LAST_WORD),
                                 $urandom, pick_levels());
                end
            endcase
        end

        // Synchronous reset, held low from time zero and released at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every transaction has been taken and answered, then keep the clock
        // running for a drain period so that any result it should not have shows up.
        while (pending_accesses.size() != 0 || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/gpio_rb_pkg.sv
design/gpio_rb_front.sv
design/gpio_rb_back.sv
design/gpio_register_block_core.sv
tb/sv/gpio_register_block_core_test.sv
